/* design/first_fit_extent_allocator_top_assert.svh */
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_TOP_ASSERT_SVH

// check the consequent in the same cycle
`define FFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// check the consequent in the next cycle
`define FFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ffe_pkg.sv */
package ffe_pkg;

    localparam int FREE_ENTRIES = 64;
    localparam int FILE_ENTRIES = 64;
    localparam int ADDR_BITS = 20;
    localparam int ID_BITS = 16;
    localparam int SIZE_BITS = 16;
    localparam int CFG_SIZE_BITS = 16;

    localparam int FREE_IDX_BITS = $clog2(FREE_ENTRIES);
    localparam int FILE_IDX_BITS = $clog2(FILE_ENTRIES);
    localparam int SCAN_MAX = (FREE_ENTRIES > FILE_ENTRIES) ? FREE_ENTRIES : FILE_ENTRIES;
    localparam int SCAN_BITS = $clog2(SCAN_MAX + 1);

    localparam int FREE_WORD_BITS = 2 * ADDR_BITS;
    localparam int FILE_WORD_BITS = ID_BITS + ADDR_BITS + SIZE_BITS;

    localparam logic [ADDR_BITS-1:0] DISK_RESET = ADDR_BITS'(368640);
    localparam logic [CFG_SIZE_BITS-1:0] MIN_RESET = CFG_SIZE_BITS'(18);
    localparam logic [CFG_SIZE_BITS-1:0] MAX_RESET = CFG_SIZE_BITS'(32768);

    localparam int PADDR_BITS = 4;
    localparam logic [1:0] REG_DISK_TOTAL = 2'd0;
    localparam logic [1:0] REG_MIN_SIZE = 2'd1;
    localparam logic [1:0] REG_MAX_SIZE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_DUP       = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic                     reinit;
        logic [ADDR_BITS-1:0]     cap;
        logic [CFG_SIZE_BITS-1:0] min_size;
        logic [CFG_SIZE_BITS-1:0] max_size;
    } cfg_t;

endpackage

/* design/first_fit_extent_allocator_top.sv */
// Sequence: an allocate or free is accepted in S_IDLE, scans the file table in S_FSCAN, then the
// free table in S_ASCAN or S_DSCAN, commits in S_ACOMMIT or S_DCOMMIT and loads its result in
// S_DONE; duplicate id, file table full, not found and zero-size free answer after the file scan,
// a bad-size allocate goes straight to S_DONE. One item at a time: the next item is taken the
// cycle after the result is loaded. A result not yet taken stalls the next one before output.
// Reset: synchronous, active low; free table holds [0, 368640), file table empty, limits 18
// and 32768. A write of disk_total reinitializes both tables at once.
module first_fit_extent_allocator_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ffe_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic [ffe_pkg::ID_BITS-1:0]          s_file_id,
    input  logic [ffe_pkg::SIZE_BITS-1:0]        s_request_size,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_status,
    output logic [ffe_pkg::ADDR_BITS-1:0]        m_start_address,
    output logic [ffe_pkg::SIZE_BITS-1:0]        m_extent_size
);

    localparam int AB = ffe_pkg::ADDR_BITS;
    localparam int CS = ffe_pkg::CFG_SIZE_BITS;

    logic [AB-1:0] disk_reg, disk_next;
    logic [CS-1:0] min_reg, min_next;
    logic [CS-1:0] max_reg, max_next;
    logic wr;
    logic [1:0] widx;
    ffe_pkg::cfg_t cfg;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign widx = paddr[3:2];

    always_comb begin
        disk_next = disk_reg;
        min_next = min_reg;
        max_next = max_reg;
        cfg.reinit = 1'b0;
        if (wr) begin
            unique case (widx)
                ffe_pkg::REG_DISK_TOTAL: begin
                    disk_next = pwdata[AB-1:0];
                    cfg.reinit = 1'b1;
                end
                ffe_pkg::REG_MIN_SIZE: min_next = pwdata[CS-1:0];
                ffe_pkg::REG_MAX_SIZE: max_next = pwdata[CS-1:0];
                default: begin
                end
            endcase
        end
        cfg.cap = pwdata[AB-1:0];
        cfg.min_size = min_reg;
        cfg.max_size = max_reg;
    end

    always_comb begin
        unique case (widx)
            ffe_pkg::REG_DISK_TOTAL: prdata = 32'(disk_reg);
            ffe_pkg::REG_MIN_SIZE: prdata = 32'(min_reg);
            ffe_pkg::REG_MAX_SIZE: prdata = 32'(max_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_reg <= ffe_pkg::DISK_RESET;
            min_reg <= ffe_pkg::MIN_RESET;
            max_reg <= ffe_pkg::MAX_RESET;
        end else begin
            disk_reg <= disk_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    ffe_engine u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_file_id       (s_file_id),
        .s_request_size  (s_request_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_start_address (m_start_address),
        .m_extent_size   (m_extent_size)
    );

endmodule

/* design/ffe_ram.sv */
module ffe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/ffe_engine.sv */
`include "first_fit_extent_allocator_top_assert.svh"

module ffe_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ffe_pkg::cfg_t                       cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [ffe_pkg::ID_BITS-1:0]         s_file_id,
    input  logic [ffe_pkg::SIZE_BITS-1:0]       s_request_size,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic [ffe_pkg::ADDR_BITS-1:0]       m_start_address,
    output logic [ffe_pkg::SIZE_BITS-1:0]       m_extent_size
);

    localparam int AB = ffe_pkg::ADDR_BITS;
    localparam int SB = ffe_pkg::SIZE_BITS;
    localparam int IB = ffe_pkg::ID_BITS;
    localparam int FRB = ffe_pkg::FREE_IDX_BITS;
    localparam int FLB = ffe_pkg::FILE_IDX_BITS;
    localparam int CB = ffe_pkg::SCAN_BITS;
    localparam int NFR = ffe_pkg::FREE_ENTRIES;
    localparam int NFL = ffe_pkg::FILE_ENTRIES;
    localparam logic [CB-1:0] FREE_END = CB'(NFR);
    localparam logic [CB-1:0] FILE_END = CB'(NFL);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FSCAN   = 7'b0000010,
        S_ASCAN   = 7'b0000100,
        S_DSCAN   = 7'b0001000,
        S_ACOMMIT = 7'b0010000,
        S_DCOMMIT = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic pv_reg, pv_next;
    logic [CB-1:0] pidx_reg, pidx_next;
    logic op_reg, op_next;
    logic [IB-1:0] id_reg, id_next;
    logic [SB-1:0] req_reg, req_next;

    logic hit_reg, hit_next;
    logic [FLB-1:0] hit_idx_reg, hit_idx_next;
    logic [AB-1:0] hit_start_reg, hit_start_next;
    logic [SB-1:0] hit_size_reg, hit_size_next;
    logic slot_reg, slot_next;
    logic [FLB-1:0] slot_idx_reg, slot_idx_next;

    logic best_reg, best_next;
    logic [FRB-1:0] best_idx_reg, best_idx_next;
    logic [AB-1:0] best_start_reg, best_start_next;
    logic [AB-1:0] best_size_reg, best_size_next;

    logic lo_reg, lo_next;
    logic [FRB-1:0] lo_idx_reg, lo_idx_next;
    logic [AB-1:0] lo_start_reg, lo_start_next;
    logic [AB-1:0] lo_size_reg, lo_size_next;
    logic hi_reg, hi_next;
    logic [FRB-1:0] hi_idx_reg, hi_idx_next;
    logic [AB-1:0] hi_size_reg, hi_size_next;
    logic emp_reg, emp_next;
    logic [FRB-1:0] emp_idx_reg, emp_idx_next;

    ffe_pkg::status_t res_status_reg, res_status_next;
    logic [AB-1:0] res_start_reg, res_start_next;
    logic [SB-1:0] res_size_reg, res_size_next;

    logic m_valid_reg, m_valid_next;
    ffe_pkg::status_t m_status_reg, m_status_next;
    logic [AB-1:0] m_start_reg, m_start_next;
    logic [SB-1:0] m_size_reg, m_size_next;

    logic [NFR-1:0] free_valid_reg, free_valid_next;
    logic [NFL-1:0] file_valid_reg, file_valid_next;
    logic init0_reg, init0_next;
    logic [AB-1:0] cap_reg, cap_next;

    logic fr_we;
    logic [FRB-1:0] fr_waddr;
    logic [ffe_pkg::FREE_WORD_BITS-1:0] fr_wdata, fr_rdata;
    logic fl_we;
    logic [FLB-1:0] fl_waddr;
    logic [ffe_pkg::FILE_WORD_BITS-1:0] fl_wdata, fl_rdata;

    logic [FRB-1:0] pfr;
    logic [FLB-1:0] pfl;
    logic fv, lv;
    logic [AB-1:0] fr_start, fr_size;
    logic [IB-1:0] fl_id;
    logic [AB-1:0] fl_start;
    logic [SB-1:0] fl_size;
    logic [AB-1:0] req_ext, n_ext;
    logic [AB:0] fr_end, hit_end;
    logic bad_size;

    ffe_ram #(.WIDTH(ffe_pkg::FREE_WORD_BITS), .DEPTH(NFR)) u_free_ram (
        .aclk  (aclk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (cnt_reg[FRB-1:0]),
        .rdata (fr_rdata)
    );

    ffe_ram #(.WIDTH(ffe_pkg::FILE_WORD_BITS), .DEPTH(NFL)) u_file_ram (
        .aclk  (aclk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (cnt_reg[FLB-1:0]),
        .rdata (fl_rdata)
    );

    assign pfr = pidx_reg[FRB-1:0];
    assign pfl = pidx_reg[FLB-1:0];
    assign fv = free_valid_reg[pfr];
    assign lv = file_valid_reg[pfl];
    assign fr_start = (init0_reg && pfr == '0) ? '0 : fr_rdata[2*AB-1:AB];
    assign fr_size = (init0_reg && pfr == '0) ? cap_reg : fr_rdata[AB-1:0];
    assign fl_id = fl_rdata[IB+AB+SB-1:AB+SB];
    assign fl_start = fl_rdata[AB+SB-1:SB];
    assign fl_size = fl_rdata[SB-1:0];
    assign req_ext = AB'(req_reg);
    assign n_ext = AB'(hit_size_reg);
    assign fr_end = {1'b0, fr_start} + {1'b0, fr_size};
    assign hit_end = {1'b0, hit_start_reg} + {1'b0, n_ext};
    assign bad_size = (s_request_size < cfg.min_size) || (s_request_size > cfg.max_size);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_start_address = m_start_reg;
    assign m_extent_size = m_size_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pv_next = 1'b0;
        pidx_next = cnt_reg;
        op_next = op_reg;
        id_next = id_reg;
        req_next = req_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        hit_start_next = hit_start_reg;
        hit_size_next = hit_size_reg;
        slot_next = slot_reg;
        slot_idx_next = slot_idx_reg;
        best_next = best_reg;
        best_idx_next = best_idx_reg;
        best_start_next = best_start_reg;
        best_size_next = best_size_reg;
        lo_next = lo_reg;
        lo_idx_next = lo_idx_reg;
        lo_start_next = lo_start_reg;
        lo_size_next = lo_size_reg;
        hi_next = hi_reg;
        hi_idx_next = hi_idx_reg;
        hi_size_next = hi_size_reg;
        emp_next = emp_reg;
        emp_idx_next = emp_idx_reg;
        res_status_next = res_status_reg;
        res_start_next = res_start_reg;
        res_size_next = res_size_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_start_next = m_start_reg;
        m_size_next = m_size_reg;
        free_valid_next = free_valid_reg;
        file_valid_next = file_valid_reg;
        init0_next = init0_reg;
        cap_next = cap_reg;
        fr_we = 1'b0;
        fr_waddr = '0;
        fr_wdata = '0;
        fl_we = 1'b0;
        fl_waddr = '0;
        fl_wdata = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next = s_opcode;
                    id_next = s_file_id;
                    req_next = s_request_size;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    slot_next = 1'b0;
                    best_next = 1'b0;
                    lo_next = 1'b0;
                    hi_next = 1'b0;
                    emp_next = 1'b0;
                    if (s_opcode == ffe_pkg::OP_ALLOC && bad_size) begin
                        res_status_next = ffe_pkg::ST_BAD_SIZE;
                        res_start_next = '0;
                        res_size_next = '0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FSCAN;
                    end
                end
            end
            S_FSCAN: begin
                if (cnt_reg != FILE_END) begin
                    cnt_next = cnt_reg + CB'(1);
                    pv_next = 1'b1;
                end
                if (pv_reg) begin
                    if (lv && fl_id == id_reg && !hit_reg) begin
                        hit_next = 1'b1;
                        hit_idx_next = pfl;
                        hit_start_next = fl_start;
                        hit_size_next = fl_size;
                    end
                    if (!lv && !slot_reg) begin
                        slot_next = 1'b1;
                        slot_idx_next = pfl;
                    end
                end else if (cnt_reg == FILE_END) begin
                    cnt_next = '0;
                    res_start_next = '0;
                    res_size_next = '0;
                    state_next = S_DONE;
                    if (op_reg == ffe_pkg::OP_ALLOC) begin
                        if (hit_reg) begin
                            res_status_next = ffe_pkg::ST_DUP;
                        end else if (!slot_reg) begin
                            res_status_next = ffe_pkg::ST_FULL;
                        end else begin
                            state_next = S_ASCAN;
                        end
                    end else begin
                        if (!hit_reg) begin
                            res_status_next = ffe_pkg::ST_NOT_FOUND;
                        end else if (hit_size_reg == '0) begin
                            file_valid_next[hit_idx_reg] = 1'b0;
                            res_status_next = ffe_pkg::ST_OK;
                            res_start_next = hit_start_reg;
                        end else begin
                            state_next = S_DSCAN;
                        end
                    end
                end
            end
            S_ASCAN, S_DSCAN: begin
                if (cnt_reg != FREE_END) begin
                    cnt_next = cnt_reg + CB'(1);
                    pv_next = 1'b1;
                end
                if (pv_reg) begin
                    if (state_reg == S_ASCAN) begin
                        if (fv && fr_size >= req_ext && (!best_reg || fr_start < best_start_reg)) begin
                            best_next = 1'b1;
                            best_idx_next = pfr;
                            best_start_next = fr_start;
                            best_size_next = fr_size;
                        end
                    end else if (!fv) begin
                        if (!emp_reg) begin
                            emp_next = 1'b1;
                            emp_idx_next = pfr;
                        end
                    end else if (fr_end == {1'b0, hit_start_reg}) begin
                        lo_next = 1'b1;
                        lo_idx_next = pfr;
                        lo_start_next = fr_start;
                        lo_size_next = fr_size;
                    end else if ({1'b0, fr_start} == hit_end) begin
                        hi_next = 1'b1;
                        hi_idx_next = pfr;
                        hi_size_next = fr_size;
                    end
                end else if (cnt_reg == FREE_END) begin
                    state_next = (state_reg == S_ASCAN) ? S_ACOMMIT : S_DCOMMIT;
                end
            end
            S_ACOMMIT: begin
                state_next = S_DONE;
                if (!best_reg) begin
                    res_status_next = ffe_pkg::ST_NO_SPACE;
                    res_start_next = '0;
                    res_size_next = '0;
                end else begin
                    if (best_size_reg == req_ext) begin
                        if (req_reg != '0) begin
                            free_valid_next[best_idx_reg] = 1'b0;
                        end
                    end else begin
                        fr_we = 1'b1;
                        fr_waddr = best_idx_reg;
                        fr_wdata = {best_start_reg + req_ext, best_size_reg - req_ext};
                        if (best_idx_reg == '0) begin
                            init0_next = 1'b0;
                        end
                    end
                    fl_we = 1'b1;
                    fl_waddr = slot_idx_reg;
                    fl_wdata = {id_reg, best_start_reg, req_reg};
                    file_valid_next[slot_idx_reg] = 1'b1;
                    res_status_next = ffe_pkg::ST_OK;
                    res_start_next = best_start_reg;
                    res_size_next = req_reg;
                end
            end
            S_DCOMMIT: begin
                state_next = S_DONE;
                res_status_next = ffe_pkg::ST_OK;
                res_start_next = hit_start_reg;
                res_size_next = hit_size_reg;
                fr_we = 1'b1;
                if (lo_reg && hi_reg) begin
                    fr_waddr = lo_idx_reg;
                    fr_wdata = {lo_start_reg, lo_size_reg + n_ext + hi_size_reg};
                    free_valid_next[hi_idx_reg] = 1'b0;
                end else if (lo_reg) begin
                    fr_waddr = lo_idx_reg;
                    fr_wdata = {lo_start_reg, lo_size_reg + n_ext};
                end else if (hi_reg) begin
                    fr_waddr = hi_idx_reg;
                    fr_wdata = {hit_start_reg, hi_size_reg + n_ext};
                end else if (emp_reg) begin
                    fr_waddr = emp_idx_reg;
                    fr_wdata = {hit_start_reg, n_ext};
                    free_valid_next[emp_idx_reg] = 1'b1;
                end else begin
                    fr_we = 1'b0;
                    res_status_next = ffe_pkg::ST_FULL;
                    res_start_next = '0;
                    res_size_next = '0;
                end
                if (fr_we) begin
                    file_valid_next[hit_idx_reg] = 1'b0;
                    if (fr_waddr == '0) begin
                        init0_next = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_start_next = res_start_reg;
                    m_size_next = res_size_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.reinit) begin
            free_valid_next = '0;
            free_valid_next[0] = (cfg.cap != '0);
            file_valid_next = '0;
            init0_next = 1'b1;
            cap_next = cfg.cap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            pv_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            free_valid_reg <= NFR'(1);
            file_valid_reg <= '0;
            init0_reg <= 1'b1;
            cap_reg <= ffe_pkg::DISK_RESET;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pv_reg <= pv_next;
            m_valid_reg <= m_valid_next;
            free_valid_reg <= free_valid_next;
            file_valid_reg <= file_valid_next;
            init0_reg <= init0_next;
            cap_reg <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= pidx_next;
        op_reg <= op_next;
        id_reg <= id_next;
        req_reg <= req_next;
        hit_reg <= hit_next;
        hit_idx_reg <= hit_idx_next;
        hit_start_reg <= hit_start_next;
        hit_size_reg <= hit_size_next;
        slot_reg <= slot_next;
        slot_idx_reg <= slot_idx_next;
        best_reg <= best_next;
        best_idx_reg <= best_idx_next;
        best_start_reg <= best_start_next;
        best_size_reg <= best_size_next;
        lo_reg <= lo_next;
        lo_idx_reg <= lo_idx_next;
        lo_start_reg <= lo_start_next;
        lo_size_reg <= lo_size_next;
        hi_reg <= hi_next;
        hi_idx_reg <= hi_idx_next;
        hi_size_reg <= hi_size_next;
        emp_reg <= emp_next;
        emp_idx_reg <= emp_idx_next;
        res_status_reg <= res_status_next;
        res_start_reg <= res_start_next;
        res_size_reg <= res_size_next;
        m_status_reg <= m_status_next;
        m_start_reg <= m_start_next;
        m_size_reg <= m_size_next;
    end

    `FFE_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "engine still ready after taking an item")
    `FFE_ASSERT_SAME(a_error_zero, m_valid && m_status != ffe_pkg::ST_OK,
        m_start_address == '0 && m_extent_size == '0, "error result carries an extent")
    `FFE_ASSERT_NEXT(a_file_written_valid, fl_we && !cfg.reinit,
        file_valid_reg[$past(fl_waddr)], "written file entry not marked valid")
    `FFE_ASSERT_SAME(a_one_write_per_commit, fr_we || fl_we,
        state_reg == S_ACOMMIT || state_reg == S_DCOMMIT, "table write outside commit")

endmodule
